>>> hdl/lkvs_pkg.sv
package lkvs_pkg;

  // Operation codes carried on opcode_i
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } opcode_e;

  // Fixed field widths
  localparam int OP_W  = 1;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  // Capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

>>> hdl/lru_key_value_store.sv
// Channel   Direction  Handshake                  Payload
// -------   ---------  -------------------------  --------------------------------
// command   in         start (taken when !busy)   opcode_i, lookup_key_i, value_in_i
// result    out        done_o strobe, one cycle   hit_o, value_out_o
// config    in         cfg_valid_i / cfg_ready_o  cfg_data_i (capacity limit)
//
// One command per cycle; busy stays low, so a command is taken on every edge with start.
// done_o rises with the result, which is registered in order: input register, then a
// combinational pass (parallel key compare, rank update) into the result register.
// Reset clears the pipeline valids and the slot fill count and sets the capacity register
// to sixteen; slot contents are left as they are and are only read below the fill count.
// The result side has no backpressure: each result is presented for exactly one cycle.
module lru_key_value_store #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command beat
  input  logic                                start,
  output logic                                busy,
  input  logic [lkvs_pkg::OP_W-1:0]           opcode_i,
  input  logic signed [lkvs_pkg::KEY_W-1:0]   lookup_key_i,
  input  logic signed [lkvs_pkg::VAL_W-1:0]   value_in_i,
  // result beat
  output logic                                done_o,
  output logic                                hit_o,
  output logic signed [lkvs_pkg::VAL_W-1:0]   value_out_o,
  // configuration beat
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lkvs_pkg::CAP_W-1:0]          cfg_data_i
);

  import lkvs_pkg::*;

  localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int RnkW = IdxW;
  localparam int CntW = $clog2(SLOT_COUNT + 1);
  localparam int CmpW = (CntW > CAP_W) ? CntW : CAP_W;

  // Input register
  logic               in_vld_q;
  logic [OP_W-1:0]    in_op_q;
  logic [KEY_W-1:0]   in_key_q;
  logic [VAL_W-1:0]   in_val_q;

  // Slot storage
  logic [KEY_W-1:0]   slot_key_q  [SLOT_COUNT];
  logic [VAL_W-1:0]   slot_val_q  [SLOT_COUNT];
  logic [RnkW-1:0]    slot_rank_q [SLOT_COUNT];
  logic [CntW-1:0]    slots_used_q, slots_used_d;
  logic [CAP_W-1:0]   cap_q;

  // Result register
  logic               done_q;
  logic               hit_q;
  logic [VAL_W-1:0]   val_out_q, val_out_d;

  // Lookup signals
  logic [SLOT_COUNT-1:0] in_use, match, victim, fill_sel, sel, age;
  logic                  found, fill, is_put, upd;
  logic [RnkW-1:0]       hit_rank, last_rank;
  logic [VAL_W-1:0]      hit_val;
  logic [CmpW-1:0]       cap_eff, used_ext;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Effective capacity: zero acts as one, clamp at the slot count
  always_comb begin
    cap_eff = CmpW'(cap_q);
    if (cap_q == '0) begin
      cap_eff = CmpW'(1);
    end
    if (cap_eff > CmpW'(SLOT_COUNT)) begin
      cap_eff = CmpW'(SLOT_COUNT);
    end
  end

  assign used_ext  = CmpW'(slots_used_q);
  assign last_rank = RnkW'(slots_used_q - CntW'(1));
  assign is_put    = (in_op_q == OP_PUT);

  // Parallel search over the slots in use; keys are unique so matches are one-hot
  always_comb begin
    hit_rank = '0;
    hit_val  = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      in_use[i]   = CntW'(i) < slots_used_q;
      match[i]    = in_use[i] && (slot_key_q[i] == in_key_q);
      victim[i]   = in_use[i] && (slot_rank_q[i] == last_rank);
      fill_sel[i] = CntW'(i) == slots_used_q;
      hit_rank    = hit_rank | (match[i] ? slot_rank_q[i] : '0);
      hit_val     = hit_val  | (match[i] ? slot_val_q[i]  : '0);
    end
  end

  assign found = |match;
  assign fill  = !found && (used_ext < cap_eff);
  assign sel   = found ? match : (fill ? fill_sel : victim);
  assign upd   = in_vld_q && (found || is_put);

  // Slots that age by one when the target becomes most recent
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      age[i] = in_use[i] && !sel[i] && (!found || (slot_rank_q[i] < hit_rank));
    end
  end

  // Fill count and result value
  always_comb begin
    slots_used_d = slots_used_q;
    if (in_vld_q && is_put && fill) begin
      slots_used_d = slots_used_q + CntW'(1);
    end
    val_out_d = (!is_put && found) ? hit_val : '0;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      done_q       <= 1'b0;
      slots_used_q <= '0;
      cap_q        <= CAP_RESET;
    end else begin
      in_vld_q     <= start && !busy;
      done_q       <= in_vld_q;
      slots_used_q <= slots_used_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // Input and result payload
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_op_q  <= opcode_i;
      in_key_q <= lookup_key_i;
      in_val_q <= value_in_i;
    end
    if (in_vld_q) begin
      hit_q     <= found;
      val_out_q <= val_out_d;
    end
  end

  // Slot contents and recency ranks (0 is most recent)
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (in_vld_q && is_put && sel[i]) begin
        slot_val_q[i] <= in_val_q;
        if (!found) begin
          slot_key_q[i] <= in_key_q;
        end
      end
      if (upd) begin
        if (sel[i]) begin
          slot_rank_q[i] <= '0;
        end else if (age[i]) begin
          slot_rank_q[i] <= slot_rank_q[i] + RnkW'(1);
        end
      end
    end
  end

  assign done_o      = done_q;
  assign hit_o       = hit_q;
  assign value_out_o = val_out_q;

`ifndef SYNTH
  // Every taken command gives a result beat on done_o
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("command without result");

  // Fill count never passes the slot count
  a_used_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_ext <= CmpW'(SLOT_COUNT))
    else $error("slot fill count overflow");

  // Fill count never shrinks
  a_used_mono : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> slots_used_q >= $past(slots_used_q))
    else $error("slot fill count decreased");

  // A miss never returns data
  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (value_out_o == '0))
    else $error("data on a miss");
`endif

endmodule

>>> bench/testbench.sv
module testbench;
  import lkvs_pkg::*;

  localparam int SLOTS     = 16;
  localparam int RANK_W    = $clog2(SLOTS);
  localparam int POOL_SIZE = 24;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES    = 9;
  localparam int PHASE_ITEMS = 184;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value;
  } lookup_result_t;

  // Block ports; the inputs are driven to known values from time zero
  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [OP_W-1:0]            opcode_i = OP_GET;
  logic signed [KEY_W-1:0]    lookup_key_i = '0;
  logic signed [VAL_W-1:0]    value_in_i = '0;
  logic                       done_o;
  logic                       hit_o;
  logic signed [VAL_W-1:0]    value_out_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CAP_W-1:0]           cfg_data_i = '0;

  // Shadow copy of the store contents and recency order
  logic [KEY_W-1:0]  shadow_key [SLOTS];
  logic [VAL_W-1:0]  shadow_val [SLOTS];
  logic [RANK_W-1:0] shadow_rank [SLOTS];
  int unsigned       shadow_used = 0;
  logic [CAP_W-1:0]  shadow_cap = CAP_RESET;

  lookup_result_t    expected_lookups [$];
  logic [KEY_W-1:0]  key_pool [POOL_SIZE];
  int unsigned       idle_pct = 23;
  int unsigned       mismatch_count = 0;
  int unsigned       idle_cycles = 0;

  lru_key_value_store #(
    .SLOT_COUNT (SLOTS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .lookup_key_i (lookup_key_i),
    .value_in_i   (value_in_i),
    .done_o       (done_o),
    .hit_o        (hit_o),
    .value_out_o  (value_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // LRU predictor
  // ---------------------------------------------------------------------------

  // move slot s to the front; entries that were newer age by one
  function automatic void lru_promote(int unsigned s);
    logic [RANK_W-1:0] r;
    r = shadow_rank[s];
    for (int i = 0; i < shadow_used; i++) begin
      if (shadow_rank[i] < r) shadow_rank[i]++;
    end
    shadow_rank[s] = '0;
  endfunction

  function automatic int unsigned effective_capacity(logic [CAP_W-1:0] cap);
    if (cap == 0) return 1;
    if (cap > SLOTS) return SLOTS;
    return cap;
  endfunction

  // apply one get/put to the shadow store and return the result it produces
  function automatic lookup_result_t lru_access(opcode_e op, logic [KEY_W-1:0] key,
                                                logic [VAL_W-1:0] val);
    lookup_result_t    res;
    logic              found;
    int unsigned       slot;
    logic [RANK_W-1:0] oldest;
    found = 1'b0;
    slot  = 0;
    for (int i = 0; i < shadow_used; i++) begin
      if (!found && shadow_key[i] == key) begin
        found = 1'b1;
        slot  = i;
      end
    end
    res.hit   = found;
    res.value = '0;
    if (op == OP_GET) begin
      if (found) begin
        lru_promote(slot);
        res.value = shadow_val[slot];
      end
    end else if (found) begin
      // put of a resident key: update in place
      shadow_val[slot] = val;
      lru_promote(slot);
    end else begin
      if (shadow_used < effective_capacity(shadow_cap)) begin
        for (int i = 0; i < shadow_used; i++) shadow_rank[i]++;
        slot = shadow_used;
        shadow_used++;
        shadow_rank[slot] = '0;
      end else begin
        // evict the oldest slot in use
        oldest = '0;
        slot   = 0;
        for (int i = 0; i < shadow_used; i++) begin
          if (shadow_rank[i] > oldest) begin
            oldest = shadow_rank[i];
            slot   = i;
          end
        end
        lru_promote(slot);
      end
      shadow_key[slot] = key;
      shadow_val[slot] = val;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // one command beat, with random idle cycles ahead of it
  task automatic send_cmd(opcode_e op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start        <= 1'b0;
      lookup_key_i <= $urandom;
      value_in_i   <= $urandom;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    opcode_i     <= op;
    lookup_key_i <= key;
    value_in_i   <= val;
    do @(posedge clk_i); while (busy);
    expected_lookups.push_back(lru_access(op, key, val));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk_i);
  endtask

  // capacity write; only called with nothing in flight
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow_cap = cap;
  endtask

  function automatic logic [KEY_W-1:0] pick_key(int unsigned span);
    if ($urandom_range(99) < 80) return key_pool[$urandom_range(span - 1)];
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && done_o) begin
      if (expected_lookups.size() == 0) begin
        report_mismatch("unexpected result beat", {31'b0, hit_o}, value_out_o);
      end else begin
        want = expected_lookups.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", {31'b0, hit_o}, {31'b0, want.hit});
        if (value_out_o !== want.value) report_mismatch("value_out", value_out_o, want.value);
      end
    end
  end

  // watchdog: cycles with no beat of any kind
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // empty store, field extremes, hits, misses, update in place
  task automatic test_empty_store();
    send_cmd(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_cmd(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_cmd(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_cmd(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_cmd(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_cmd(OP_GET, 32'h8000_0000, 32'h1234_5678);
    send_cmd(OP_GET, 32'h7FFF_FFFF, 32'h0);
    send_cmd(OP_GET, 32'hFFFF_FFFF, 32'h0);
    send_cmd(OP_GET, 32'h0000_0005, 32'h0);
    send_cmd(OP_PUT, 32'h7FFF_FFFF, 32'h0000_007B);
    send_cmd(OP_GET, 32'h7FFF_FFFF, 32'h0);
  endtask

  // capacity zero, capacity below fill count, capacity above slot count
  task automatic test_capacity_extremes();
    wait_drained();
    write_capacity(5'd0);
    send_cmd(OP_PUT, 32'h0000_0007, 32'h0000_0046);
    send_cmd(OP_GET, 32'h0000_0007, 32'h0);
    send_cmd(OP_PUT, 32'h0000_0008, 32'h0000_0050);
    send_cmd(OP_GET, 32'h0000_0007, 32'h0);
    wait_drained();
    write_capacity(5'd31);
    send_cmd(OP_PUT, 32'h0000_0009, 32'h0000_005A);
    send_cmd(OP_GET, 32'h0000_0008, 32'h0);
  endtask

  // random gets and puts over a key span of the effective capacity plus four, capped at the pool size
  task automatic test_random_traffic(logic [CAP_W-1:0] cap, int unsigned items);
    int unsigned span;
    wait_drained();
    write_capacity(cap);
    span = effective_capacity(cap) + 4;
    if (span > POOL_SIZE) span = POOL_SIZE;
    for (int n = 0; n < items; n++) begin
      send_cmd(opcode_e'($urandom_range(1)), pick_key(span), $urandom);
    end
  endtask

  initial begin
    logic [CAP_W-1:0] phase_caps [PHASES];
    phase_caps = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd2, 5'd17, 5'd12, 5'd16};

    // key pool: field extremes plus random keys
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_store();
    test_capacity_extremes();
    for (int p = 0; p < PHASES; p++) begin
      idle_pct = (p < 3) ? 23 : (p < 6) ? 75 : 0;
      test_random_traffic(phase_caps[p], PHASE_ITEMS);
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
